### rtl/kprt_pkg.sv
package kprt_pkg;

  localparam int unsigned IdW = 48;

  typedef enum logic [1:0] {
    CMD_UPSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_DONE     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_COUNT,
    S_SORT,
    S_OUT
  } fsm_t;

  // per-cycle control from sequencer to the list cells
  typedef struct packed {
    logic load;     // write slot into cell at load position
    logic shift;    // cells at and above pos take neighbour above
    logic swap;     // swap cell at pos-1 and pos
  } cell_ctrl_t;

endpackage

### rtl/kprt_cell.sv
module kprt_cell #(
  parameter int SW = 3
) (
  input  logic          clk,
  input  logic          load,
  input  logic          take_up,
  input  logic          take_down,
  input  logic [SW-1:0] load_val,
  input  logic [SW-1:0] up_val,
  input  logic [SW-1:0] down_val,
  output logic [SW-1:0] val
);

  always_ff @(posedge clk) begin
    if (load) begin
      val <= load_val;
    end else if (take_up) begin
      val <= up_val;
    end else if (take_down) begin
      val <= down_val;
    end
  end

endmodule

### rtl/keyed_peer_table_with_ready_sort_unit.sv
// an upsert that inserts a new peer runs a bubble sort on the list;
// update, remove, read and clear requests do not sort
// one request at a time; the next request is taken in the cycle after the result is accepted
// rst synchronous: table empty, ready_age back to 9
module keyed_peer_table_with_ready_sort_unit #(
  parameter int MAX_PEERS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command[1:0], peer_identity[49:2], peer_attribute[57:50],
  // peer_sort_key[65:58], target_slot[68:66], list_position[71:69]
  input  logic [71:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], slot_index[5:3], entry_count[9:6], ready_count[13:10],
  // attribute_changed[14], order_changed[15], read_identity[63:16],
  // read_sort_key[71:64], read_attribute[79:72], read_age[87:80], read_valid[88]
  output logic [95:0]  m_axis_tdata,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_data
);

  localparam int SW = $clog2(MAX_PEERS);
  localparam int CW = $clog2(MAX_PEERS + 1);

  kprt_pkg::fsm_t state, state_next;

  logic [7:0] ready_age;
  logic [kprt_pkg::IdW-1:0] id_mem [MAX_PEERS];
  logic [7:0] key_mem [MAX_PEERS];
  logic [7:0] attr_mem [MAX_PEERS];
  logic [7:0] age_mem [MAX_PEERS];
  logic [MAX_PEERS-1:0] active;
  logic [CW-1:0] len;

  logic [71:0] req;
  logic [1:0] cmd;
  logic [kprt_pkg::IdW-1:0] rq_id;
  logic [7:0] rq_attr, rq_key;
  logic [2:0] rq_tgt, rq_pos;
  logic tgt_ok;

  logic [CW-1:0] idx;
  logic [CW-1:0] nready;
  logic [CW-1:0] pass;
  logic found;
  logic [SW-1:0] fslot;
  logic achg, ochg;
  logic [2:0] status;
  logic [2:0] slot_out;
  logic [kprt_pkg::IdW-1:0] rid;
  logic [7:0] rkey, rattr, rage;
  logic rvalid;

  logic [SW-1:0] list [MAX_PEERS];
  kprt_pkg::cell_ctrl_t ctrl;
  logic [SW-1:0] load_val;
  logic [SW-1:0] ip;

  assign cmd     = req[1:0];
  assign rq_id   = req[49:2];
  assign rq_attr = req[57:50];
  assign rq_key  = req[65:58];
  assign rq_tgt  = req[68:66];
  assign rq_pos  = req[71:69];
  assign ip      = idx[SW-1:0];
  assign tgt_ok  = 32'(rq_tgt) < 32'(MAX_PEERS);

  // lowest free slot
  logic [SW-1:0] free_slot;
  logic free_ok;
  always_comb begin
    free_slot = '0;
    free_ok = 1'b0;
    for (int i = MAX_PEERS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_slot = SW'(i);
        free_ok = 1'b1;
      end
    end
  end

  logic [SW-1:0] cur_slot, prv_slot;
  logic in_list, at_top;
  assign in_list  = idx < len;
  assign cur_slot = list[ip];
  assign prv_slot = list[SW'(idx - CW'(1))];
  assign at_top   = idx == CW'(MAX_PEERS);

  logic sort_go;
  assign sort_go = (idx != '0) && (idx > pass) && (key_mem[cur_slot] > key_mem[prv_slot]);

  genvar g;
  generate
    for (g = 0; g < MAX_PEERS; g++) begin : g_cell
      logic ld, tu, td;
      logic [SW-1:0] up, dn;
      assign ld = ctrl.load && (ip == SW'(g));
      assign tu = (ctrl.shift && (SW'(g) >= ip) && (g < MAX_PEERS - 1))
                  || (ctrl.swap && (SW'(g) == SW'(idx - CW'(1))));
      assign td = ctrl.swap && (SW'(g) == ip) && (g > 0);
      if (g < MAX_PEERS - 1) begin : g_up
        assign up = list[g+1];
      end else begin : g_noup
        assign up = list[g];
      end
      if (g > 0) begin : g_dn
        assign dn = list[g-1];
      end else begin : g_nodn
        assign dn = list[g];
      end
      kprt_cell #(.SW(SW)) u_cell (
        .clk(clk), .load(ld), .take_up(tu), .take_down(td),
        .load_val(load_val), .up_val(up), .down_val(dn), .val(list[g])
      );
    end
  endgenerate

  assign load_val = free_slot;

  always_comb begin
    state_next = state;
    unique case (state)
      kprt_pkg::S_IDLE: if (s_axis_tvalid) state_next = kprt_pkg::S_SCAN;
      kprt_pkg::S_SCAN: begin
        if (cmd == kprt_pkg::CMD_CLEAR || cmd == kprt_pkg::CMD_READ) begin
          state_next = kprt_pkg::S_COUNT;
        end else if (!in_list || at_top) begin
          state_next = kprt_pkg::S_COUNT;
        end else if (cmd == kprt_pkg::CMD_UPSERT && id_mem[cur_slot] == rq_id) begin
          state_next = kprt_pkg::S_COUNT;
        end else if (cmd == kprt_pkg::CMD_REMOVE && cur_slot == SW'(rq_tgt) && tgt_ok) begin
          state_next = kprt_pkg::S_SHIFT;
        end
      end
      kprt_pkg::S_SHIFT: state_next = kprt_pkg::S_COUNT;
      kprt_pkg::S_COUNT: begin
        if (!in_list || at_top || age_mem[cur_slot] < ready_age) begin
          if (cmd == kprt_pkg::CMD_UPSERT && status == kprt_pkg::ST_INSERTED
              && !found && idx >= CW'(2))
            state_next = kprt_pkg::S_SORT;
          else
            state_next = kprt_pkg::S_OUT;
        end
      end
      kprt_pkg::S_SORT: if (pass + CW'(1) >= nready) state_next = kprt_pkg::S_COUNT;
      kprt_pkg::S_OUT: if (m_axis_tready) state_next = kprt_pkg::S_IDLE;
      default: state_next = kprt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = state == kprt_pkg::S_IDLE;
    m_axis_tvalid = state == kprt_pkg::S_OUT;
  end

  // the COUNT after SORT recounts; found flags that the sort already ran or that there was nothing to sort
  always_comb begin
    ctrl = '0;
    if (state == kprt_pkg::S_SHIFT) ctrl.shift = 1'b1;
    if (state == kprt_pkg::S_SCAN && cmd == kprt_pkg::CMD_UPSERT
        && (!in_list || at_top) && free_ok && len < CW'(MAX_PEERS))
      ctrl.load = 1'b1;
    if (state == kprt_pkg::S_SORT && sort_go) ctrl.swap = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kprt_pkg::S_IDLE;
      ready_age <= 8'd9;
      active <= '0;
      len <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) ready_age <= cfg_data;
      unique case (state)
        kprt_pkg::S_IDLE: begin
          req <= s_axis_tdata;
          idx <= '0;
          found <= 1'b0;
          achg <= 1'b0;
          ochg <= 1'b0;
          status <= kprt_pkg::ST_DONE;
          slot_out <= '0;
          rid <= '0; rkey <= '0; rattr <= '0; rage <= '0; rvalid <= 1'b0;
          nready <= '0;
        end
        kprt_pkg::S_SCAN: begin
          unique case (cmd)
            kprt_pkg::CMD_CLEAR: begin
              len <= '0;
              active <= '0;
              idx <= '0;
            end
            kprt_pkg::CMD_READ: begin
              idx <= '0;
              if (32'(rq_pos) < 32'(len)) begin
                slot_out <= 3'(list[SW'(rq_pos)]);
                rid <= id_mem[list[SW'(rq_pos)]];
                rkey <= key_mem[list[SW'(rq_pos)]];
                rattr <= attr_mem[list[SW'(rq_pos)]];
                rage <= age_mem[list[SW'(rq_pos)]];
                rvalid <= 1'b1;
              end
            end
            kprt_pkg::CMD_UPSERT: begin
              if (!in_list || at_top) begin
                idx <= '0;
                if (free_ok && len < CW'(MAX_PEERS)) begin
                  active[free_slot] <= 1'b1;
                  id_mem[free_slot] <= rq_id;
                  attr_mem[free_slot] <= rq_attr;
                  key_mem[free_slot] <= rq_key;
                  age_mem[free_slot] <= '0;
                  len <= len + CW'(1);
                  status <= kprt_pkg::ST_INSERTED;
                  slot_out <= 3'(free_slot);
                end else begin
                  status <= kprt_pkg::ST_FULL;
                end
              end else if (id_mem[cur_slot] == rq_id) begin
                key_mem[cur_slot] <= rq_key;
                if (age_mem[cur_slot] != 8'hff) age_mem[cur_slot] <= age_mem[cur_slot] + 8'd1;
                if (attr_mem[cur_slot] != rq_attr) begin
                  attr_mem[cur_slot] <= rq_attr;
                  achg <= 1'b1;
                end
                status <= kprt_pkg::ST_UPDATED;
                slot_out <= 3'(cur_slot);
                idx <= '0;
              end else begin
                idx <= idx + CW'(1);
              end
            end
            default: begin
              slot_out <= rq_tgt;
              if (!in_list || at_top) begin
                idx <= '0;
                status <= kprt_pkg::ST_NOTFOUND;
              end else if (cur_slot == SW'(rq_tgt) && tgt_ok) begin
                active[cur_slot] <= 1'b0;
                status <= kprt_pkg::ST_REMOVED;
              end else begin
                idx <= idx + CW'(1);
                status <= kprt_pkg::ST_NOTFOUND;
              end
            end
          endcase
        end
        kprt_pkg::S_SHIFT: begin
          len <= len - CW'(1);
          idx <= '0;
        end
        kprt_pkg::S_COUNT: begin
          if (!in_list || at_top || age_mem[cur_slot] < ready_age) begin
            nready <= idx;
            pass <= '0;
            idx <= idx - CW'(1);
            if (idx < CW'(2)) found <= 1'b1;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        kprt_pkg::S_SORT: begin
          if (sort_go) ochg <= 1'b1;
          if (pass + CW'(1) >= nready) begin
            idx <= '0;
            found <= 1'b1;
          end else if (idx <= pass + CW'(1)) begin
            pass <= pass + CW'(1);
            idx <= nready - CW'(1);
          end else begin
            idx <= idx - CW'(1);
          end
        end
        kprt_pkg::S_OUT: ;
        default: ;
      endcase
    end
  end

  assign m_axis_tdata = {7'd0, rvalid, rage, rattr, rkey, rid, ochg, achg,
                         4'(nready), 4'(len), slot_out, status};

endmodule
